/* rtl/grb_pkg.sv */
// shared types and constants of the grid region box check
// no dependencies; imported by every module of the block
package grb_pkg;

  localparam int COORD_W     = 10;
  localparam int CNT_W       = 31;
  localparam int MARKER_W    = 8;
  localparam int CFG_SIZE_W  = 11;
  localparam int DIM_W       = COORD_W + 1;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int VOL_W       = 3 * DIM_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int OUT_DATA_W  = 64;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CELLS_X    = 3'd0;
  localparam logic [2:0] REG_CELLS_Y    = 3'd1;
  localparam logic [2:0] REG_CELLS_Z    = 3'd2;
  localparam logic [2:0] REG_RANGE_LOW  = 3'd3;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd4;

  localparam logic [CNT_W-1:0]   COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [COORD_W-1:0] COORD_ONES  = {COORD_W{1'b1}};

  typedef logic [COORD_W-1:0] coord_t;

  // one classified cell, as it sits in the queue
  typedef struct packed {
    logic             in_range;
    logic             last;
    coord_t [2:0]     pos;
  } cell_t;

  // finished bounding box of one grid
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] count;
    coord_t [2:0]     lo;
    coord_t [2:0]     hi;
  } box_t;

  typedef enum logic [1:0] {
    RES_IDLE,
    RES_MUL1,
    RES_MUL2,
    RES_SEND
  } res_state_t;

endpackage

/* rtl/grb_front.sv */
// front end: accepts cells, classifies the marker and tracks raster position
// depends on grb_pkg
module grb_front
  import grb_pkg::*;
#(
  parameter int MAX_AXIS_CELLS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MARKER_W-1:0]   marker,
  input  logic                  last,
  input  logic [CFG_SIZE_W-1:0] cells_x,
  input  logic [CFG_SIZE_W-1:0] cells_y,
  input  logic [CFG_SIZE_W-1:0] cells_z,
  input  logic [MARKER_W-1:0]   range_low,
  input  logic [MARKER_W-1:0]   range_high,
  input  logic                  q_full,
  output logic                  q_push,
  output cell_t                 q_data
);

  localparam int POS_W = $clog2(MAX_AXIS_CELLS);
  localparam int SZ_W  = (POS_W + 1 > CFG_SIZE_W) ? POS_W + 1 : CFG_SIZE_W;
  localparam logic [SZ_W-1:0] MaxSize = SZ_W'(MAX_AXIS_CELLS);

  function automatic logic [SZ_W-1:0] eff_size(logic [CFG_SIZE_W-1:0] n);
    logic [SZ_W-1:0] w;
    w = SZ_W'(n);
    if (n == '0) begin
      return SZ_W'(1);
    end
    if (w > MaxSize) begin
      return MaxSize;
    end
    return w;
  endfunction

  logic [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [POS_W:0]   x_inc, y_inc, z_inc;
  logic             wrap_x, wrap_y, wrap_z;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign q_data.in_range = (marker >= range_low) && (marker <= range_high);
  assign q_data.last     = last;
  assign q_data.pos[0]   = COORD_W'(pos_x_r);
  assign q_data.pos[1]   = COORD_W'(pos_y_r);
  assign q_data.pos[2]   = COORD_W'(pos_z_r);

  assign x_inc  = {1'b0, pos_x_r} + 1'b1;
  assign y_inc  = {1'b0, pos_y_r} + 1'b1;
  assign z_inc  = {1'b0, pos_z_r} + 1'b1;
  assign wrap_x = SZ_W'(x_inc) >= eff_size(cells_x);
  assign wrap_y = SZ_W'(y_inc) >= eff_size(cells_y);
  assign wrap_z = SZ_W'(z_inc) >= eff_size(cells_z);

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (q_push) begin
      if (last) begin
        pos_x_nxt = '0;
        pos_y_nxt = '0;
        pos_z_nxt = '0;
      end else if (!wrap_x) begin
        pos_x_nxt = x_inc[POS_W-1:0];
      end else begin
        pos_x_nxt = '0;
        if (!wrap_y) begin
          pos_y_nxt = y_inc[POS_W-1:0];
        end else begin
          pos_y_nxt = '0;
          pos_z_nxt = wrap_z ? '0 : z_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

endmodule

/* rtl/grb_queue.sv */
// short show-ahead queue of classified cells between front and back
// depends on grb_pkg
module grb_queue
  import grb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  cell_t push_data,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output cell_t pop_data
);

  cell_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/grb_accum.sv */
// back end: running min/max corners and saturating in-range count per grid
// depends on grb_pkg; hands the finished box to grb_result
module grb_accum
  import grb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  cell_t q_data,
  output logic  q_pop,
  output logic  box_valid,
  input  logic  box_ready,
  output box_t  box
);

  coord_t [2:0]     lo_r, hi_r, lo_upd, hi_upd, lo_nxt, hi_nxt;
  logic             found_r, found_upd, found_nxt;
  logic [CNT_W-1:0] count_r, count_upd, count_nxt;
  logic             box_valid_r, box_valid_nxt;
  box_t             box_r, box_nxt;

  // a last cell waits until the box slot is free
  assign q_pop     = q_valid && (!q_data.last || !box_valid_r || box_ready);
  assign box_valid = box_valid_r;
  assign box       = box_r;

  always_comb begin
    lo_upd    = lo_r;
    hi_upd    = hi_r;
    found_upd = found_r;
    count_upd = count_r;
    if (q_data.in_range) begin
      for (int i = 0; i < 3; i++) begin
        if (!found_r || q_data.pos[i] < lo_r[i]) begin
          lo_upd[i] = q_data.pos[i];
        end
        if (!found_r || q_data.pos[i] > hi_r[i]) begin
          hi_upd[i] = q_data.pos[i];
        end
      end
      found_upd = 1'b1;
      if (count_r != COUNT_MAX) begin
        count_upd = count_r + 1'b1;
      end
    end
  end

  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    found_nxt     = found_r;
    count_nxt     = count_r;
    box_nxt       = box_r;
    box_valid_nxt = box_valid_r && !box_ready;
    if (q_pop) begin
      if (q_data.last) begin
        box_nxt.found = found_upd;
        box_nxt.count = count_upd;
        box_nxt.lo    = lo_upd;
        box_nxt.hi    = hi_upd;
        box_valid_nxt = 1'b1;
        lo_nxt        = {3{COORD_ONES}};
        hi_nxt        = '0;
        found_nxt     = 1'b0;
        count_nxt     = '0;
      end else begin
        lo_nxt    = lo_upd;
        hi_nxt    = hi_upd;
        found_nxt = found_upd;
        count_nxt = count_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    box_r <= box_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r        <= {3{COORD_ONES}};
      hi_r        <= '0;
      found_r     <= 1'b0;
      count_r     <= '0;
      box_valid_r <= 1'b0;
    end else begin
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      found_r     <= found_nxt;
      count_r     <= count_nxt;
      box_valid_r <= box_valid_nxt;
    end
  end

endmodule

/* rtl/grb_result.sv */
// result stage: box volume over two multiply steps, then the output register
// depends on grb_pkg; fed by grb_accum
module grb_result
  import grb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  box_valid,
  output logic                  box_ready,
  input  box_t                  box,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  res_state_t        state_r, state_nxt;
  box_t              box_r;
  logic [PROD_W-1:0] prod_r;
  logic [VOL_W-1:0]  vol_r;
  logic [DIM_W-1:0]  dim [3];
  logic              strippable;
  coord_t [2:0]      lo_out, hi_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dim[i] = {1'b0, box_r.hi[i]} - {1'b0, box_r.lo[i]} + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      RES_IDLE: if (box_valid) state_nxt = RES_MUL1;
      RES_MUL1: state_nxt = RES_MUL2;
      RES_MUL2: state_nxt = RES_SEND;
      RES_SEND: if (out_ready) state_nxt = RES_IDLE;
      default:  state_nxt = RES_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    box_ready  = state_r == RES_IDLE;
    out_valid  = state_r == RES_SEND;
    strippable = box_r.found && ((VOL_W)'(box_r.count) == vol_r);
    for (int i = 0; i < 3; i++) begin
      lo_out[i] = box_r.found ? box_r.lo[i] : '0;
      hi_out[i] = box_r.found ? box_r.hi[i] : '0;
    end
    out_data = {2'b00, hi_out[2], hi_out[1], hi_out[0],
                lo_out[2], lo_out[1], lo_out[0], box_r.found, strippable};
  end

  always_ff @(posedge clk) begin
    if (state_r == RES_IDLE && box_valid) begin
      box_r <= box;
    end
    if (state_r == RES_MUL1) begin
      prod_r <= PROD_W'(dim[0]) * PROD_W'(dim[1]);
    end
    if (state_r == RES_MUL2) begin
      vol_r <= VOL_W'(prod_r) * VOL_W'(dim[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RES_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/grid_region_box_check.sv */
// grid region box check top level: config registers, front, queue, back, result
// depends on grb_pkg, grb_front, grb_queue, grb_accum, grb_result
// last cell to result valid: queue, box register, RES_MUL1, RES_MUL2, RES_SEND
// throughput: one cell per cycle while the queue is not full; the result stage holds
//   one grid until its output is taken, and the next box waits in the box register
// reset: synchronous active-low rst_n clears positions, corners, count, queue and
//   output valid; sizes return to 1 and both range bounds to 0
module grid_region_box_check
  import grb_pkg::*;
#(
  parameter int MAX_AXIS_CELLS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [MARKER_W-1:0]   in_tdata,   // [7:0] marker
  input  logic                  in_tlast,   // last cell of the grid
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] strippable, [1] any_in_range, [11:2] box_min_x, [21:12] box_min_y,
  // [31:22] box_min_z, [41:32] box_max_x, [51:42] box_max_y, [61:52] box_max_z,
  // [63:62] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // configuration registers
  logic [CFG_SIZE_W-1:0] cells_x_r, cells_y_r, cells_z_r;
  logic [MARKER_W-1:0]   range_low_r, range_high_r;
  logic                  cfg_wr;
  logic [2:0]            cfg_idx;

  // front to queue, queue to back, back to result
  logic  q_push, q_pop, q_full, q_not_empty;
  cell_t q_in, q_out;
  logic  box_valid, box_ready;
  box_t  box;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  // register file write, one register per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r    <= CFG_SIZE_W'(1);
      cells_y_r    <= CFG_SIZE_W'(1);
      cells_z_r    <= CFG_SIZE_W'(1);
      range_low_r  <= '0;
      range_high_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CELLS_X:    cells_x_r    <= cfg_pwdata[CFG_SIZE_W-1:0];
        REG_CELLS_Y:    cells_y_r    <= cfg_pwdata[CFG_SIZE_W-1:0];
        REG_CELLS_Z:    cells_z_r    <= cfg_pwdata[CFG_SIZE_W-1:0];
        REG_RANGE_LOW:  range_low_r  <= cfg_pwdata[MARKER_W-1:0];
        REG_RANGE_HIGH: range_high_r <= cfg_pwdata[MARKER_W-1:0];
        default:        ;
      endcase
    end
  end

  // read mux, addresses past the list read as zero
  always_comb begin
    unique case (cfg_idx)
      REG_CELLS_X:    cfg_prdata = 32'(cells_x_r);
      REG_CELLS_Y:    cfg_prdata = 32'(cells_y_r);
      REG_CELLS_Z:    cfg_prdata = 32'(cells_z_r);
      REG_RANGE_LOW:  cfg_prdata = 32'(range_low_r);
      REG_RANGE_HIGH: cfg_prdata = 32'(range_high_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // front: takes cells, tags in-range and raster position
  grb_front #(
    .MAX_AXIS_CELLS (MAX_AXIS_CELLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .marker     (in_tdata),
    .last       (in_tlast),
    .cells_x    (cells_x_r),
    .cells_y    (cells_y_r),
    .cells_z    (cells_z_r),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  // queue decouples the front from a back end stalled on a full result stage
  grb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  // back: per-grid corners and count
  grb_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box)
  );

  // result: volume product, count compare and output register
  grb_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  // a strippable region always has at least one in-range cell
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[0] || out_tdata[1]))
    else $error("strippable without any in-range cell");

  // box corners are ordered whenever a box exists
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |->
      (out_tdata[11:2] <= out_tdata[41:32]) &&
      (out_tdata[21:12] <= out_tdata[51:42]) &&
      (out_tdata[31:22] <= out_tdata[61:52]))
    else $error("box minimum above maximum");

  // empty result reports an all-zero box
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[1]) |-> (out_tdata[63:2] == '0))
    else $error("empty result with nonzero box");

endmodule
